>>> rtl/drt_pkg.sv
// Shared types, constants and helpers for the dirty rectangle tracker.
package drt_pkg;

   localparam int CHAN_W         = 8;
   localparam int PIX_W          = 32;
   localparam int DIM_W          = 10;
   localparam int COORD_W        = 9;
   localparam int DIM_MAX        = 1023;
   localparam int DIM_RESET      = 512;
   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [PIX_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_FRAME_WIDTH  = 1'b0;
   localparam csr_idx_type REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } req_data_type;

   typedef struct packed {
      logic               any_change;
      logic               whole_frame;
      logic [COORD_W-1:0] left_col;
      logic [COORD_W-1:0] top_row;
      logic [COORD_W-1:0] right_col;
      logic [COORD_W-1:0] bottom_row;
   } rsp_data_type;

   // zero reads as one, anything above the limit reads as the limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned lim);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (32'(v) > lim) begin
         return DIM_W'(lim);
      end
      return v;
   endfunction

endpackage

>>> rtl/drt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
module drt_ram #(
   parameter int WIDTH = drt_pkg::PIX_W,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read during write to the same address returns the old word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/dirty_rectangle_tracker_top.sv
// Dirty rectangle tracker: pixel cache compare and changed-box accumulation.
//
// Usage:
//  - req channel: one RGBA pixel per transaction, raster order. The block
//    counts column and row itself up to the programmed frame size.
//  - rsp channel: one transaction per frame, issued after the frame's last
//    pixel: change flag, whole-frame flag and the changed box corners.
//  - csr port: frame_width at 0x0, frame_height at 0x4. Program while idle.
//    Any write drops the frame in progress; a new size also makes the whole
//    cache read as opaque black again.
//  - Throughput: one pixel per clock while req_stall is low. The cache RAM
//    takes one read (incoming pixel) and one write-back (pixel in compare).
//  - Result path: accepting the last pixel loads the compare stage and the
//    RAM read; the rsp register, and so rsp_valid, loads when that stage fires.
//  - Reset: sizes return to 512x512 (clamped to the maximums), counters and
//    change flag clear, a fill count marks every cache entry opaque black.
//    No sweep of the RAM is needed, so pixels are taken right after reset.
//  - Receiver stall: the result is held in the rsp register. Pixels keep
//    flowing; req_stall rises only when the next frame's last pixel reaches
//    the compare stage while the previous result is still waiting.
module dirty_rectangle_tracker_top #(
   parameter int MAX_WIDTH  = drt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = drt_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  drt_pkg::req_data_type           req_data,
   // frame result
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output drt_pkg::rsp_data_type           rsp_data,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [drt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [drt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [drt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   import drt_pkg::*;

   // Column/row ranges: the size registers are 10 bits, so a maximum above
   // 1023 can never be reached.
   localparam int COL_MAX     = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
   localparam int ROW_MAX     = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
   localparam int COL_W       = (COL_MAX > 1) ? $clog2(COL_MAX) : 1;
   localparam int ROW_W       = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
   localparam int CACHE_DEPTH = COL_MAX * ROW_MAX;
   localparam int ADDR_W      = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(CACHE_DEPTH + 1);

   localparam logic [DIM_W-1:0] FW_RESET = clamp_dim(DIM_W'(DIM_RESET), MAX_WIDTH);
   localparam logic [DIM_W-1:0] FH_RESET = clamp_dim(DIM_W'(DIM_RESET), MAX_HEIGHT);

   // ---------------------------------------------------------------- csr
   logic              cfg_wr;
   csr_idx_type       cfg_idx;
   logic [DIM_W-1:0]  fw_ff, fw_in;
   logic [DIM_W-1:0]  fh_ff, fh_in;
   logic [DIM_W-1:0]  fw_new, fh_new;
   logic              size_change;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // register index is the word address; byte offset bits are ignored
   assign cfg_idx    = csr_paddr[CSR_ADDR_W-1 -: CSR_IDX_W];
   assign fw_new     = clamp_dim(csr_pwdata[DIM_W-1:0], MAX_WIDTH);
   assign fh_new     = clamp_dim(csr_pwdata[DIM_W-1:0], MAX_HEIGHT);

   always_comb begin
      csr_prdata = '0;
      unique case (cfg_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(fw_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(fh_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      size_change = 1'b0;
      if (cfg_wr) begin
         unique case (cfg_idx)
            REG_FRAME_WIDTH: begin
               fw_in       = fw_new;
               size_change = (fw_new != fw_ff);
            end
            REG_FRAME_HEIGHT: begin
               fh_in       = fh_new;
               size_change = (fh_new != fh_ff);
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- stage 0: intake
   // Raster counters plus a linear cache address (row * width + col, kept
   // as a running count so no multiply is needed).
   logic              req_accept;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              col_wrap, row_wrap, frame_last;
   logic [PIX_W-1:0]  pix_word;

   assign req_accept = req_valid & ~req_stall;
   assign col_wrap   = ((DIM_W+1)'(col_ff) + (DIM_W+1)'(1)) >= {1'b0, fw_ff};
   assign row_wrap   = ((DIM_W+1)'(row_ff) + (DIM_W+1)'(1)) >= {1'b0, fh_ff};
   assign frame_last = col_wrap & row_wrap;
   assign pix_word   = {req_data.alpha, req_data.blue, req_data.green, req_data.red};

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      addr_in = addr_ff;
      if (cfg_wr) begin
         col_in  = '0;
         row_in  = '0;
         addr_in = '0;
      end else if (req_accept) begin
         if (frame_last) begin
            col_in  = '0;
            row_in  = '0;
            addr_in = '0;
         end else if (col_wrap) begin
            col_in  = '0;
            row_in  = row_ff + ROW_W'(1);
            addr_in = addr_ff + ADDR_W'(1);
         end else begin
            col_in  = col_ff + COL_W'(1);
            addr_in = addr_ff + ADDR_W'(1);
         end
      end
   end

   // --------------------------------------------- stage 1: compare / update
   logic              s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_last_ff;
   logic              s1_filled_ff;
   logic              s1_fwd_ff;
   logic [PIX_W-1:0]  s1_fwd_pix_ff;
   logic              s1_block, s1_fire;
   logic [PIX_W-1:0]  ram_rdata, cached;
   logic              pix_diff;

   // The last pixel can only leave when the rsp register is free or
   // being drained this cycle; everything upstream waits behind it.
   assign s1_block  = s1_valid_ff & s1_last_ff & rsp_valid & rsp_stall;
   assign s1_fire   = s1_valid_ff & ~s1_block;
   assign req_stall = s1_block;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Fill count: entries below it were written since the last refill, the
   // rest read as opaque black. Raster order always writes the next one.
   logic [FILL_W-1:0] fill_ff, fill_in;

   always_comb begin
      fill_in = fill_ff;
      if (size_change) begin
         fill_in = '0;
      end else if (s1_fire && (FILL_W'(s1_addr_ff) == fill_ff)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   // Every pixel is written back (an unchanged word rewrites itself), which
   // keeps the fill count simple.
   drt_ram #(
      .WIDTH (PIX_W),
      .DEPTH (CACHE_DEPTH)
   ) u_cache (
      .clock (clock),
      .we    (s1_fire),
      .waddr (s1_addr_ff),
      .wdata (s1_pix_ff),
      .re    (req_accept),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // Forwarding covers a 1x1 frame, where back-to-back pixels hit one entry.
   assign cached   = s1_fwd_ff    ? s1_fwd_pix_ff :
                     s1_filled_ff ? ram_rdata     : OPAQUE_BLACK;
   assign pix_diff = (cached != s1_pix_ff);

   // ---------------------------------------------------------- changed box
   logic              change_seen_ff, change_seen_in;
   logic [COL_W-1:0]  box_left_ff, box_right_ff, box_left_in, box_right_in;
   logic [ROW_W-1:0]  box_top_ff, box_bottom_ff, box_top_in, box_bottom_in;
   logic              seen_n, hit, whole;

   assign hit    = s1_fire & pix_diff;
   assign seen_n = change_seen_ff | hit;

   always_comb begin
      box_left_in   = box_left_ff;
      box_right_in  = box_right_ff;
      box_top_in    = box_top_ff;
      box_bottom_in = box_bottom_ff;
      if (hit) begin
         if (!change_seen_ff) begin
            // first change of the frame seeds the box
            box_left_in   = s1_col_ff;
            box_right_in  = s1_col_ff;
            box_top_in    = s1_row_ff;
            box_bottom_in = s1_row_ff;
         end else begin
            if (s1_col_ff < box_left_ff)   box_left_in   = s1_col_ff;
            if (s1_col_ff > box_right_ff)  box_right_in  = s1_col_ff;
            if (s1_row_ff < box_top_ff)    box_top_in    = s1_row_ff;
            if (s1_row_ff > box_bottom_ff) box_bottom_in = s1_row_ff;
         end
      end
   end

   // box spans the frame exactly when it touches both edges in each axis
   assign whole = (box_left_in == '0) && (box_top_in == '0) &&
                  (DIM_W'(box_right_in)  == (fw_ff - DIM_W'(1))) &&
                  (DIM_W'(box_bottom_in) == (fh_ff - DIM_W'(1)));

   always_comb begin
      change_seen_in = change_seen_ff;
      if (cfg_wr) begin
         change_seen_in = 1'b0;
      end else if (s1_fire) begin
         change_seen_in = s1_last_ff ? 1'b0 : seen_n;
      end
   end

   // ------------------------------------------------------------ rsp reg
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic [DIM_W-1:0] left_ext, right_ext, top_ext, bottom_ext;

   assign left_ext   = DIM_W'(box_left_in);
   assign right_ext  = DIM_W'(box_right_in);
   assign top_ext    = DIM_W'(box_top_in);
   assign bottom_ext = DIM_W'(box_bottom_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (seen_n) begin
            rsp_data_in.any_change  = 1'b1;
            rsp_data_in.whole_frame = whole;
            rsp_data_in.left_col    = left_ext[COORD_W-1:0];
            rsp_data_in.top_row     = top_ext[COORD_W-1:0];
            rsp_data_in.right_col   = right_ext[COORD_W-1:0];
            rsp_data_in.bottom_row  = bottom_ext[COORD_W-1:0];
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff          <= FW_RESET;
         fh_ff          <= FH_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         addr_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         fill_ff        <= '0;
         change_seen_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fw_ff          <= fw_in;
         fh_ff          <= fh_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         addr_ff        <= addr_in;
         s1_valid_ff    <= s1_valid_in;
         fill_ff        <= fill_in;
         change_seen_ff <= change_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff     <= pix_word;
         s1_col_ff     <= col_ff;
         s1_row_ff     <= row_ff;
         s1_addr_ff    <= addr_ff;
         s1_last_ff    <= frame_last;
         s1_filled_ff  <= (FILL_W'(addr_ff) < fill_ff);
         s1_fwd_ff     <= s1_fire && (s1_addr_ff == addr_ff);
         s1_fwd_pix_ff <= s1_pix_ff;
      end
      box_left_ff   <= box_left_in;
      box_right_ff  <= box_right_in;
      box_top_ff    <= box_top_in;
      box_bottom_ff <= box_bottom_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

>>> rtl/drt_checker.sv
// Port-level checks for the dirty rectangle tracker, bound to the top level.
module drt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input drt_pkg::rsp_data_type rsp_data
);

   import drt_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // a frame without changes reports all zeros
   a_no_change_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.any_change |->
         !rsp_data.whole_frame && rsp_data.left_col == '0 &&
         rsp_data.top_row == '0 && rsp_data.right_col == '0 &&
         rsp_data.bottom_row == '0)
      else $error("empty frame result carries box data");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.any_change |->
         rsp_data.left_col <= rsp_data.right_col &&
         rsp_data.top_row <= rsp_data.bottom_row &&
         (!rsp_data.whole_frame ||
          (rsp_data.left_col == '0 && rsp_data.top_row == '0)))
      else $error("changed box corners out of order");

   // intake only backs up behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

endmodule

bind dirty_rectangle_tracker_top drt_checker u_drt_checker (.*);

>>> verif/tb.sv
// Self-checking testbench for the dirty rectangle tracker.
module tb;
   import drt_pkg::*;

   localparam int FRAME_MAX_W   = DEF_MAX_WIDTH;
   localparam int FRAME_MAX_H   = DEF_MAX_HEIGHT;
   localparam int RANDOM_PIXELS = 400;
   // rsp trails the last pixel; leave margin before a size write
   localparam int SETTLE_CYCLES = 8;
   localparam int STUCK_LIMIT   = 5000;
   localparam int REPORT_LIMIT  = 10;

   localparam req_data_type BLACK_PIXEL = '{red: 8'h00, green: 8'h00, blue: 8'h00,
                                            alpha: 8'hFF};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_data_type          req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dirty_rectangle_tracker_top u_top (.*);

   always #5 clock = ~clock;

   // idle percentages per traffic mode: receiver-heavy stall, sender-heavy, none
   int send_idle_pct [3] = '{27, 82, 0};
   int recv_idle_pct [3] = '{82, 27, 0};
   int idle_mode = 0;

   // ---------------------------------------------------------------------
   // Frame tracking mirror: cache image, raster position, changed box.
   // Cache entries that were never written read as opaque black; a size
   // change simply empties the associative array.
   // ---------------------------------------------------------------------
   req_data_type frame_cache [int];
   int cur_width  = (DIM_RESET > FRAME_MAX_W) ? FRAME_MAX_W : DIM_RESET;
   int cur_height = (DIM_RESET > FRAME_MAX_H) ? FRAME_MAX_H : DIM_RESET;
   int cur_col, cur_row;
   bit frame_dirty;
   int box_left, box_top, box_right, box_bottom;

   rsp_data_type frame_reports [$];   // expected per-frame results, oldest first
   req_data_type pixel_q [$];         // pixels waiting to be driven

   // stimulus-side copy of the scene, so frames can repeat cached content
   req_data_type scene_plan [int];
   int plan_col, plan_row, plan_pct;

   int fail_count = 0;

   function automatic void start_new_frame();
      cur_col     = 0;
      cur_row     = 0;
      frame_dirty = 1'b0;
      box_left    = cur_width;
      box_top     = cur_height;
      box_right   = 0;
      box_bottom  = 0;
   endfunction

   // append one pixel at the tail of the driver queue
   function automatic void queue_pixel(req_data_type px);
      pixel_q.insert(pixel_q.size(), px);
   endfunction

   function automatic req_data_type cached_pixel(int idx);
      return frame_cache.exists(idx) ? frame_cache[idx] : BLACK_PIXEL;
   endfunction

   // One accepted pixel: update cache and box, queue a report on the last pixel.
   function automatic void track_pixel(req_data_type px);
      int           idx;
      bit           last;
      rsp_data_type rpt;
      idx = cur_row * cur_width + cur_col;
      if (cached_pixel(idx) != px) begin
         frame_cache[idx] = px;
         frame_dirty = 1'b1;
         if (cur_col < box_left) box_left = cur_col;
         if (cur_row < box_top) box_top = cur_row;
         if (cur_col > box_right) box_right = cur_col;
         if (cur_row > box_bottom) box_bottom = cur_row;
      end
      last = (cur_col + 1 >= cur_width) && (cur_row + 1 >= cur_height);
      if (cur_col + 1 >= cur_width) begin
         cur_col = 0;
         cur_row++;
      end else begin
         cur_col++;
      end
      if (last) begin
         rpt = '0;
         // an unchanged frame reports all zeros
         if (frame_dirty) begin
            rpt.any_change  = 1'b1;
            rpt.whole_frame = (box_right - box_left + 1 == cur_width) &&
                              (box_bottom - box_top + 1 == cur_height);
            rpt.left_col    = COORD_W'(box_left);
            rpt.top_row     = COORD_W'(box_top);
            rpt.right_col   = COORD_W'(box_right);
            rpt.bottom_row  = COORD_W'(box_bottom);
         end
         frame_reports.insert(frame_reports.size(), rpt);
         start_new_frame();
      end
   endfunction

   // Only the low DIM_W bits count; zero means one, above the max means the max.
   function automatic int effective_size(logic [CSR_DATA_W-1:0] wdata, int lim);
      int v;
      v = int'(wdata[DIM_W-1:0]);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // Any size write drops the frame in progress; only a new value clears the cache.
   function automatic void apply_frame_size(csr_idx_type reg_sel,
                                            logic [CSR_DATA_W-1:0] wdata);
      int v;
      case (reg_sel)
         REG_FRAME_WIDTH: begin
            v = effective_size(wdata, FRAME_MAX_W);
            if (v != cur_width) begin
               cur_width = v;
               frame_cache.delete();
            end
         end
         REG_FRAME_HEIGHT: begin
            v = effective_size(wdata, FRAME_MAX_H);
            if (v != cur_height) begin
               cur_height = v;
               frame_cache.delete();
            end
         end
         default: ;
      endcase
      start_new_frame();
   endfunction

   function automatic void report_error(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("tb: mismatch: %s", msg);
   endfunction

   function automatic void check_field(string name, logic [COORD_W-1:0] exp_v,
                                       logic [COORD_W-1:0] act_v);
      if (exp_v !== act_v)
         report_error($sformatf("%s expected %0d got %0d", name, exp_v, act_v));
   endfunction

   // Size value as written on the bus: sometimes zero for one, sometimes junk
   // above the register width.
   function automatic logic [CSR_DATA_W-1:0] size_word(int dim);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'(dim);
      if (dim == 1 && $urandom_range(1) == 0) word = '0;
      if ($urandom_range(3) == 0) word[CSR_DATA_W-1:DIM_W] = (CSR_DATA_W-DIM_W)'($urandom());
      return word;
   endfunction

   // ---------------------------------------------------------------------
   // Pixel driver: a new transaction is offered only once the previous one
   // is taken, so the payload holds while req_stall is high.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) track_pixel(req_data);
         if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct[idle_mode]) begin
            req_valid <= 1'b1;
            req_data  <= pixel_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: random back-pressure, then in-order field compare.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : report_monitor
      rsp_data_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct[idle_mode]);
         if (rsp_valid && !rsp_stall) begin
            if (frame_reports.size() == 0) begin
               report_error("frame result with none pending");
            end else begin
               want = frame_reports.pop_front();
               check_field("any_change", want.any_change, rsp_data.any_change);
               check_field("whole_frame", want.whole_frame, rsp_data.whole_frame);
               check_field("left_col", want.left_col, rsp_data.left_col);
               check_field("top_row", want.top_row, rsp_data.top_row);
               check_field("right_col", want.right_col, rsp_data.right_col);
               check_field("bottom_row", want.bottom_row, rsp_data.bottom_row);
            end
         end
      end
   end

   // Watchdog: too long without any transaction on either channel.
   int stuck_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Setup + access phase; the register takes the value on the access edge.
   task automatic write_frame_size(csr_idx_type reg_sel, logic [CSR_DATA_W-1:0] wdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_frame_size(reg_sel, wdata);
      // nothing is in flight here, so the mirror is the true scene
      scene_plan = frame_cache;
      plan_col   = 0;
      plan_row   = 0;
   endtask

   // Queue pixels in raster order. Each frame picks how much of it changes
   // (unless forced): none, sparse, dense or all.
   task automatic plan_pixels(int count, int fixed_pct);
      int           idx;
      req_data_type px;
      repeat (count) begin
         if (plan_col == 0 && plan_row == 0) begin
            if (fixed_pct >= 0) begin
               plan_pct = fixed_pct;
            end else begin
               case ($urandom_range(9))
                  0, 1, 2:    plan_pct = 0;
                  3, 4, 5, 6: plan_pct = 10;
                  7, 8:       plan_pct = 60;
                  default:    plan_pct = 100;
               endcase
            end
         end
         idx = plan_row * cur_width + plan_col;
         px  = scene_plan.exists(idx) ? scene_plan[idx] : BLACK_PIXEL;
         if ($urandom_range(99) < plan_pct) begin
            case ($urandom_range(3))
               0, 1:    px = req_data_type'($urandom());
               2:       px = req_data_type'(px ^ (32'h1 << $urandom_range(31)));
               default: px = ($urandom_range(1) != 0) ? '1 : '0;
            endcase
         end
         scene_plan[idx] = px;
         queue_pixel(px);
         if (plan_col + 1 >= cur_width) begin
            plan_col = 0;
            plan_row = (plan_row + 1 >= cur_height) ? 0 : plan_row + 1;
         end else begin
            plan_col++;
         end
      end
   endtask

   // Wait until every pixel is taken and every frame result is in, then
   // give the pipeline time to drain a partial frame.
   task automatic wait_quiet();
      while (pixel_q.size() != 0 || req_valid || frame_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus: directed cases, random phases with size changes, then the
   // widest and tallest frames.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int           sent, frames, w, h, tail, n;
      bit           paused;
      req_data_type tint;
      req_data_type corner_frame [6];

      start_new_frame();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // partial frame at the reset size, then dropped by the first size write
      queue_pixel(BLACK_PIXEL);
      queue_pixel('{red: 8'h12, green: 8'h34, blue: 8'h56, alpha: 8'h78});
      queue_pixel(BLACK_PIXEL);
      wait_quiet();

      // zero reads as one: 1x1 frames
      write_frame_size(REG_FRAME_WIDTH, '0);
      write_frame_size(REG_FRAME_HEIGHT, '0);
      queue_pixel(BLACK_PIXEL);   // matches the cleared cache
      queue_pixel('1);            // changed, box covers the frame
      queue_pixel('1);            // same again, nothing changed
      queue_pixel('0);            // transparent black differs in every channel
      wait_quiet();

      // 3x2 frames
      write_frame_size(REG_FRAME_WIDTH, 32'd3);
      write_frame_size(REG_FRAME_HEIGHT, 32'd2);
      tint = '{red: 8'hA5, green: 8'h5A, blue: 8'hC3, alpha: 8'h3C};
      // one changed pixel at column 1 of row 0
      for (int i = 0; i < 6; i++) queue_pixel((i == 1) ? tint : BLACK_PIXEL);
      // changes in opposite corners only: box spans the frame
      foreach (corner_frame[i]) corner_frame[i] = BLACK_PIXEL;
      corner_frame[0] = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'hFE};
      corner_frame[1] = tint;
      corner_frame[5] = '{red: 8'h01, green: 8'h00, blue: 8'h00, alpha: 8'hFF};
      foreach (corner_frame[i]) queue_pixel(corner_frame[i]);
      wait_quiet();
      // same width again with junk above bit 9: cache is kept, so no change
      write_frame_size(REG_FRAME_WIDTH, 32'hFFFF_FC03);
      foreach (corner_frame[i]) queue_pixel(corner_frame[i]);
      wait_quiet();

      // random phases; traffic mode steps through the three idle settings
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_PIXELS) begin
         idle_mode = sent * 3 / RANDOM_PIXELS;
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
               7, 8: begin
                  w = $urandom_range(7, 40);
                  h = $urandom_range(1, 3);
               end
               9: begin
                  w = $urandom_range(1, 3);
                  h = $urandom_range(7, 40);
               end
               default: begin
                  w = $urandom_range(1, 6);
                  h = $urandom_range(1, 6);
               end
            endcase
         end else begin
            // rewrite the held size: frame restarts, cache stays
            w = cur_width;
            h = cur_height;
         end
         write_frame_size(REG_FRAME_WIDTH, size_word(w));
         write_frame_size(REG_FRAME_HEIGHT, size_word(h));
         frames = $urandom_range(1, (w * h > 40) ? 2 : 6);
         // sometimes leave a partial frame for the next size write to drop
         tail = ($urandom_range(3) == 0) ? $urandom_range(1, w * h) - 1 : 0;
         n    = w * h * frames + tail;
         if (!paused) begin
            // hold the sender mid-phase until every result has come back
            plan_pixels(n / 2, -1);
            wait_quiet();
            plan_pixels(n - n / 2, -1);
            paused = 1'b1;
         end else begin
            plan_pixels(n, -1);
         end
         sent += n;
         wait_quiet();
      end

      // widest frame (width above the max clamps), fully changed
      idle_mode = 2;
      write_frame_size(REG_FRAME_WIDTH, 32'd1023);
      write_frame_size(REG_FRAME_HEIGHT, 32'd1);
      plan_pixels(FRAME_MAX_W, 100);
      wait_quiet();
      // tallest frame, sparse changes
      write_frame_size(REG_FRAME_WIDTH, 32'd1);
      write_frame_size(REG_FRAME_HEIGHT, 32'd700);
      plan_pixels(FRAME_MAX_H, 10);
      wait_quiet();

      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
